[src/gnz_pkg.sv]
// ----------------------------------------------------------------------------
// gnz_pkg
// Shared types and constants for the 3d gradient noise pipeline.
// ----------------------------------------------------------------------------
package gnz_pkg;

    localparam int NUM_STAGES = 9;
    localparam int S_TDATA_W  = 112;
    localparam int FREQ_W     = 24;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd6554;
    localparam int FRAC_W     = 16;
    localparam int FADE_W     = 17;
    localparam int CELL_W     = 8;
    localparam int NUM_CORNER = 8;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] idx;
        logic [CELL_W-1:0] val;
    } perm_wr_t;

endpackage

[src/gradient_noise_3d.sv]
// ----------------------------------------------------------------------------
// gradient_noise_3d
// 3d improved gradient noise evaluator, fully pipelined.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ stream. s_tuser selects the kind: a table
// write loads one byte of the 256-entry permutation table and yields no
// result; an evaluation yields one noise sample on the m_ stream.
// The user must write the frequency register via cfg_wr_en / cfg_wr_data
// only while the block is idle; the block itself does not enforce this.
// Each item is registered in every stage; m_ shows the last stage.
// Throughput: one evaluation per cycle while m_tready is high. A table
// write waits at the input until no evaluation in the first three
// stages has lookups pending, as the three chained lookups read there.
// Reset clears all pipeline valid bits, sets frequency to about 0.1 and
// makes the table read as the identity (per-entry written flags).
// When m_tready is low, stages fill up behind the held result; empty stages
// keep accepting until the pipeline is full, then s_tready drops.
// ----------------------------------------------------------------------------
module gradient_noise_3d #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int OUT_BITS        = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [gnz_pkg::FREQ_W-1:0]        cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // table_index, table_value, coord_x, coord_y, coord_z
    input  logic [gnz_pkg::S_TDATA_W-1:0]     s_tdata,
    // req_type
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // noise_value
    output logic [((OUT_BITS+7)/8)*8-1:0]     m_tdata
);

    localparam int NS  = gnz_pkg::NUM_STAGES;
    localparam int MDW = ((OUT_BITS + 7) / 8) * 8;

    logic [gnz_pkg::FREQ_W-1:0] freq_reg;
    logic [NS:1]   vld_reg;
    logic [NS+1:1] ce_all;
    logic [NS:1]   ce;
    logic          lookup_busy;
    logic          in_acc;
    logic          is_eval;
    gnz_pkg::perm_wr_t perm_wr;

    logic [31:0]                coord [3];
    logic [gnz_pkg::CELL_W-1:0] cell_s1 [3];
    logic [gnz_pkg::FRAC_W-1:0] frac_s4 [3];
    logic [gnz_pkg::FADE_W-1:0] fade_s4 [3];
    logic [gnz_pkg::CELL_W-1:0] corner_hash [gnz_pkg::NUM_CORNER];
    logic [OUT_BITS-1:0]        noise_value;

    always_comb begin
        ce_all[NS+1] = m_tready;
        for (int i = NS; i >= 1; i--) begin
            ce_all[i] = !vld_reg[i] || ce_all[i+1];
        end
        ce = ce_all[NS:1];
    end

    assign is_eval     = (s_tuser[0] == gnz_pkg::REQ_EVAL);
    assign lookup_busy = vld_reg[1] | vld_reg[2] | vld_reg[3];
    assign s_tready    = ce[1] && (is_eval || !lookup_busy);
    assign in_acc      = s_tvalid && s_tready;

    assign perm_wr.en  = in_acc && !is_eval;
    assign perm_wr.idx = s_tdata[7:0];
    assign perm_wr.val = s_tdata[15:8];

    assign coord[0] = s_tdata[47:16];
    assign coord[1] = s_tdata[79:48];
    assign coord[2] = s_tdata[111:80];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg <= gnz_pkg::FREQ_RESET;
            vld_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                freq_reg <= cfg_wr_data;
            end
            if (ce[1]) begin
                vld_reg[1] <= in_acc && is_eval;
            end
            for (int i = 2; i <= NS; i++) begin
                if (ce[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    gnz_scale #(
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_scale (
        .aclk      (aclk),
        .ce        (ce),
        .coord     (coord),
        .frequency (freq_reg),
        .cell_s1   (cell_s1),
        .frac_s4   (frac_s4),
        .fade_s4   (fade_s4)
    );

    gnz_hash u_hash (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ce          (ce),
        .perm_wr     (perm_wr),
        .cell_s1     (cell_s1),
        .corner_hash (corner_hash)
    );

    gnz_blend #(
        .OUT_BITS(OUT_BITS)
    ) u_blend (
        .aclk        (aclk),
        .ce          (ce),
        .corner_hash (corner_hash),
        .frac_s4     (frac_s4),
        .fade_s4     (fade_s4),
        .noise_value (noise_value)
    );

    assign m_tvalid = vld_reg[NS];
    assign m_tdata  = MDW'(noise_value);

    a_write_no_pending_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        perm_wr.en |-> !(vld_reg[1] || vld_reg[2] || vld_reg[3]))
        else $error("table write while lookups pending");

    a_eval_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && is_eval |=> vld_reg[1])
        else $error("accepted evaluation lost at entry");

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        perm_wr.en |=> !vld_reg[1])
        else $error("table write produced a pipeline item");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&vld_reg) && !m_tready |-> !s_tready)
        else $error("input accepted with full stalled pipeline");

    a_stall_holds_out: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[NS] && !m_tready |=> vld_reg[NS])
        else $error("held result dropped");

endmodule

[src/gnz_scale.sv]
// ----------------------------------------------------------------------------
// gnz_scale
// Coordinate scaling, lattice split and quintic fade, stages one to four.
// ----------------------------------------------------------------------------
module gnz_scale #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic [gnz_pkg::NUM_STAGES:1]      ce,
    input  logic [31:0]                       coord [3],
    input  logic [gnz_pkg::FREQ_W-1:0]        frequency,
    output logic [gnz_pkg::CELL_W-1:0]        cell_s1 [3],
    output logic [gnz_pkg::FRAC_W-1:0]        frac_s4 [3],
    output logic [gnz_pkg::FADE_W-1:0]        fade_s4 [3]
);

    localparam int SF     = COORD_FRAC_BITS + 16;
    localparam int PROD_W = 32 + gnz_pkg::FREQ_W + 1;

    logic [gnz_pkg::CELL_W-1:0] cell_reg [3];
    logic [gnz_pkg::FRAC_W-1:0] frac1_reg [3];
    logic [gnz_pkg::FRAC_W-1:0] frac2_reg [3];
    logic [gnz_pkg::FRAC_W-1:0] frac3_reg [3];
    logic [gnz_pkg::FRAC_W-1:0] frac4_reg [3];
    logic [31:0]                t2_reg [3];
    logic [31:0]                t3_reg [3];
    logic [20:0]                q_reg [3];
    logic [gnz_pkg::FADE_W-1:0] fade_reg [3];

    logic signed [PROD_W-1:0] prod_next [3];
    logic [31:0]              t2_next [3];
    logic [47:0]              t3_full [3];
    logic [37:0]              q_full [3];
    logic [52:0]              fade_full [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod_next[k] = PROD_W'($signed(coord[k]) * $signed({1'b0, frequency}));
            t2_next[k]   = frac1_reg[k] * frac1_reg[k];
            t3_full[k]   = t2_reg[k] * frac2_reg[k];
            // 6t^2 - 15t + 10, all with 32 fraction bits (q6.32)
            q_full[k]    = 38'(6) * {6'd0, t2_reg[k]} + (38'd10 << 32)
                         - ({18'd0, 20'(frac2_reg[k] * 20'd15)} << 16);
            fade_full[k] = t3_reg[k] * q_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (ce[1]) begin
                cell_reg[k]  <= prod_next[k][SF+gnz_pkg::CELL_W-1:SF];
                frac1_reg[k] <= prod_next[k][SF-1:SF-gnz_pkg::FRAC_W];
            end
            if (ce[2]) begin
                t2_reg[k]    <= t2_next[k];
                frac2_reg[k] <= frac1_reg[k];
            end
            if (ce[3]) begin
                t3_reg[k]    <= t3_full[k][47:16];
                q_reg[k]     <= q_full[k][36:16];
                frac3_reg[k] <= frac2_reg[k];
            end
            if (ce[4]) begin
                fade_reg[k]  <= fade_full[k][48:32];
                frac4_reg[k] <= frac3_reg[k];
            end
        end
    end

    assign cell_s1 = cell_reg;
    assign frac_s4 = frac4_reg;
    assign fade_s4 = fade_reg;

endmodule

[src/gnz_hash.sv]
// ----------------------------------------------------------------------------
// gnz_hash
// Permutation table copies and the three dependent lookup stages.
// ----------------------------------------------------------------------------
module gnz_hash (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [gnz_pkg::NUM_STAGES:1]  ce,
    input  gnz_pkg::perm_wr_t             perm_wr,
    input  logic [gnz_pkg::CELL_W-1:0]    cell_s1 [3],
    output logic [gnz_pkg::CELL_W-1:0]    corner_hash [gnz_pkg::NUM_CORNER]
);

    localparam int NPORT = 14;
    localparam int DEPTH = 256;

    logic [7:0]       tbl_mem [NPORT][DEPTH];
    logic [DEPTH-1:0] ent_vld_reg;

    logic [7:0] rd_addr [NPORT];
    logic       rd_en [NPORT];
    logic [7:0] rd_data_reg [NPORT];
    logic [7:0] rd_addr_reg [NPORT];
    logic       rd_vld_reg [NPORT];
    logic [7:0] ent [NPORT];

    logic [7:0] cy_s2_reg, cz_s2_reg, cz_s3_reg;
    logic [7:0] a, b, aa, ab, ba, bb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_vld_reg <= '0;
        end else if (perm_wr.en) begin
            ent_vld_reg[perm_wr.idx] <= 1'b1;
        end
    end

    // every read port has its own copy, writes go to all of them
    always_ff @(posedge aclk) begin
        for (int p = 0; p < NPORT; p++) begin
            if (perm_wr.en) begin
                tbl_mem[p][perm_wr.idx] <= perm_wr.val;
            end
            if (rd_en[p]) begin
                rd_data_reg[p] <= tbl_mem[p][rd_addr[p]];
                rd_vld_reg[p]  <= ent_vld_reg[rd_addr[p]];
                rd_addr_reg[p] <= rd_addr[p];
            end
        end
    end

    // unwritten entries read as the identity
    always_comb begin
        for (int p = 0; p < NPORT; p++) begin
            ent[p] = rd_vld_reg[p] ? rd_data_reg[p] : rd_addr_reg[p];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce[2]) begin
            cy_s2_reg <= cell_s1[1];
            cz_s2_reg <= cell_s1[2];
        end
        if (ce[3]) begin
            cz_s3_reg <= cz_s2_reg;
        end
    end

    always_comb begin
        a  = ent[0] + cy_s2_reg;
        b  = ent[1] + cy_s2_reg;
        aa = ent[2] + cz_s3_reg;
        ab = ent[3] + cz_s3_reg;
        ba = ent[4] + cz_s3_reg;
        bb = ent[5] + cz_s3_reg;

        rd_addr[0]  = cell_s1[0];
        rd_addr[1]  = cell_s1[0] + 8'd1;
        rd_addr[2]  = a;
        rd_addr[3]  = a + 8'd1;
        rd_addr[4]  = b;
        rd_addr[5]  = b + 8'd1;
        rd_addr[6]  = aa;
        rd_addr[7]  = ba;
        rd_addr[8]  = ab;
        rd_addr[9]  = bb;
        rd_addr[10] = aa + 8'd1;
        rd_addr[11] = ba + 8'd1;
        rd_addr[12] = ab + 8'd1;
        rd_addr[13] = bb + 8'd1;

        for (int p = 0; p < NPORT; p++) begin
            if (p < 2) begin
                rd_en[p] = ce[2];
            end else if (p < 6) begin
                rd_en[p] = ce[3];
            end else begin
                rd_en[p] = ce[4];
            end
        end

        for (int c = 0; c < gnz_pkg::NUM_CORNER; c++) begin
            corner_hash[c] = ent[c + 6];
        end
    end

endmodule

[src/gnz_blend.sv]
// ----------------------------------------------------------------------------
// gnz_blend
// Corner gradients, three lerp levels and output remap, stages five to nine.
// ----------------------------------------------------------------------------
module gnz_blend #(
    parameter int OUT_BITS = 16
) (
    input  logic                          aclk,
    input  logic [gnz_pkg::NUM_STAGES:1]  ce,
    input  logic [gnz_pkg::CELL_W-1:0]    corner_hash [gnz_pkg::NUM_CORNER],
    input  logic [gnz_pkg::FRAC_W-1:0]    frac_s4 [3],
    input  logic [gnz_pkg::FADE_W-1:0]    fade_s4 [3],
    output logic [OUT_BITS-1:0]           noise_value
);

    localparam int RW = 20 + OUT_BITS;
    localparam logic [RW-1:0] MAXV = RW'((64'd1 << OUT_BITS) - 64'd1);

    typedef logic signed [18:0] val_t;
    typedef logic signed [17:0] off_t;

    function automatic val_t grad(input logic [3:0] h, input off_t x, input off_t y,
                                  input off_t z);
        val_t ga, gb;
        ga = (h < 4'd8) ? val_t'(x) : val_t'(y);
        gb = (h < 4'd4) ? val_t'(y) : ((h == 4'd12 || h == 4'd14) ? val_t'(x) : val_t'(z));
        return (h[0] ? -ga : ga) + (h[1] ? -gb : gb);
    endfunction

    function automatic val_t lerp(input logic [gnz_pkg::FADE_W-1:0] t, input val_t la,
                                  input val_t lb);
        logic signed [19:0] d;
        logic signed [37:0] p;
        d = 20'(lb) - 20'(la);
        p = $signed({1'b0, t}) * d;
        return la + val_t'(p >>> 16);
    endfunction

    val_t g_reg [8];
    val_t l_reg [4];
    val_t m_reg [2];
    val_t n_reg;
    logic [gnz_pkg::FADE_W-1:0] u5_reg, v5_reg, w5_reg, v6_reg, w6_reg, w7_reg;
    logic [OUT_BITS-1:0] out_reg;

    off_t x0, y0, z0, x1, y1, z1;
    val_t g_next [8];
    logic signed [19:0] val;
    logic [RW-1:0] sh;
    logic [OUT_BITS-1:0] out_next;

    always_comb begin
        x0 = off_t'({2'b00, frac_s4[0]});
        y0 = off_t'({2'b00, frac_s4[1]});
        z0 = off_t'({2'b00, frac_s4[2]});
        x1 = x0 - 18'sd65536;
        y1 = y0 - 18'sd65536;
        z1 = z0 - 18'sd65536;
        g_next[0] = grad(corner_hash[0][3:0], x0, y0, z0);
        g_next[1] = grad(corner_hash[1][3:0], x1, y0, z0);
        g_next[2] = grad(corner_hash[2][3:0], x0, y1, z0);
        g_next[3] = grad(corner_hash[3][3:0], x1, y1, z0);
        g_next[4] = grad(corner_hash[4][3:0], x0, y0, z1);
        g_next[5] = grad(corner_hash[5][3:0], x1, y0, z1);
        g_next[6] = grad(corner_hash[6][3:0], x0, y1, z1);
        g_next[7] = grad(corner_hash[7][3:0], x1, y1, z1);

        // map [-1,1] onto [0,1] and saturate
        val = 20'(n_reg) + 20'sd65536;
        sh  = ({{OUT_BITS{1'b0}}, val} << OUT_BITS) >> 17;
        if (val <= 20'sd0) begin
            out_next = '0;
        end else if (sh > MAXV) begin
            out_next = MAXV[OUT_BITS-1:0];
        end else begin
            out_next = sh[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce[5]) begin
            g_reg  <= g_next;
            u5_reg <= fade_s4[0];
            v5_reg <= fade_s4[1];
            w5_reg <= fade_s4[2];
        end
        if (ce[6]) begin
            for (int k = 0; k < 4; k++) begin
                l_reg[k] <= lerp(u5_reg, g_reg[2*k], g_reg[2*k+1]);
            end
            v6_reg <= v5_reg;
            w6_reg <= w5_reg;
        end
        if (ce[7]) begin
            m_reg[0] <= lerp(v6_reg, l_reg[0], l_reg[1]);
            m_reg[1] <= lerp(v6_reg, l_reg[2], l_reg[3]);
            w7_reg   <= w6_reg;
        end
        if (ce[8]) begin
            n_reg <= lerp(w7_reg, m_reg[0], m_reg[1]);
        end
        if (ce[9]) begin
            out_reg <= out_next;
        end
    end

    assign noise_value = out_reg;

endmodule
